### rtl/graph_shortest_path_reach_top_macros.svh
// Assertion helpers
`ifndef GRAPH_SHORTEST_PATH_REACH_TOP_MACROS_SVH
`define GRAPH_SHORTEST_PATH_REACH_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define GSP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gsp assertion failed");
`define GSP_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("gsp forbidden condition");
`else
`define GSP_ASSERT(lbl, prop)
`define GSP_NEVER(lbl, expr)
`endif

`endif

### rtl/gsp_pkg.sv
package gsp_pkg;

    localparam int VERTICES    = 16;
    localparam int VTX_BITS    = $clog2(VERTICES);
    localparam int CNT_BITS    = VTX_BITS + 1;
    localparam int WEIGHT_BITS = 8;
    localparam int DIST_BITS   = 12;
    localparam int EDGE_DEPTH  = VERTICES * VERTICES;
    localparam int EDGE_ABITS  = 2 * VTX_BITS;
    localparam int VCNT_BITS   = 5;
    localparam int PADDR_BITS  = 3;

    localparam logic [DIST_BITS-1:0] UNREACH_CODE = 12'hFFF;
    localparam logic [DIST_BITS-1:0] TOP_REACH    = 12'hFFE;
    localparam logic [VCNT_BITS-1:0] VCOUNT_RST   = 5'd16;
    localparam logic [DIST_BITS-1:0] LIMIT_RST    = 12'd3;

    typedef enum logic [1:0] {
        REQ_EDGE  = 2'd0,
        REQ_DIST  = 2'd1,
        REQ_REACH = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE2,
        S_SEL,
        S_REL,
        S_DIST,
        S_SCAN,
        S_FLUSH
    } t_state;

    function automatic logic [DIST_BITS-1:0] f_report(input logic [DIST_BITS-1:0] d);
        return (d > TOP_REACH) ? TOP_REACH : d;
    endfunction

endpackage

### rtl/graph_shortest_path_reach_top.sv
// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_stall   i_req_type i_vertex_a i_vertex_b i_edge_weight
// result    out        o_valid / i_stall   o_hit o_vertex_out o_path_weight o_unreachable o_last
// config    in         APB psel/penable    paddr pwdata prdata
// Set edge: one write per direction on the single RAM write port (S_IDLE, then S_EDGE2).
// Queries: per settled vertex a select pass over all vertices plus a relax pass over one
// matrix row (registered RAM read), then a final select pass.
// Then a distance query emits one result; a listing scans the vertices, then flushes the last.
// Edge weights read as zero after reset through per-entry valid flops; no clearing pass.
// The block takes one request at a time; a stalled result holds the sequencer.
`include "graph_shortest_path_reach_top_macros.svh"
module graph_shortest_path_reach_top import gsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_req_type,
    input  logic [3:0]             i_vertex_a,
    input  logic [3:0]             i_vertex_b,
    input  logic [7:0]             i_edge_weight,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_hit,
    output logic [3:0]             o_vertex_out,
    output logic [11:0]            o_path_weight,
    output logic                   o_unreachable,
    output logic                   o_last,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_BITS-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_state r_state, n_state;
    t_req   r_type, n_type;
    logic [VTX_BITS-1:0]    r_a, n_a, r_b, n_b, r_cur, n_cur;
    logic [WEIGHT_BITS-1:0] r_wt, n_wt;
    logic [CNT_BITS-1:0]    r_v, n_v;
    logic [DIST_BITS-1:0]   r_best, n_best;
    logic                   r_found, n_found;
    logic [VERTICES-1:0]    r_settled, n_settled, r_inf, n_inf;
    logic [DIST_BITS-1:0]   r_dist [VERTICES];
    logic [DIST_BITS-1:0]   n_dist [VERTICES];
    logic                   r_pend, n_pend;
    logic [VTX_BITS-1:0]    r_pvtx, n_pvtx;
    logic [DIST_BITS-1:0]   r_pw, n_pw;
    logic [VCNT_BITS-1:0]   r_vcount;
    logic [DIST_BITS-1:0]   r_limit;
    logic [EDGE_DEPTH-1:0]  r_ev;
    logic                   r_rdv;

    logic                   r_ovalid, n_ovalid;
    logic                   r_ohit, n_ohit, r_ounr, n_ounr, r_olast, n_olast;
    logic [VTX_BITS-1:0]    r_ovtx, n_ovtx;
    logic [DIST_BITS-1:0]   r_opw, n_opw;

    logic                   w_accept, w_can_emit, w_emit;
    logic                   w_ehit, w_eunr, w_elast;
    logic [VTX_BITS-1:0]    w_evtx;
    logic [DIST_BITS-1:0]   w_epw;
    logic                   wr_en;
    logic [EDGE_ABITS-1:0]  wr_addr, rd_addr;
    logic [WEIGHT_BITS-1:0] wr_data, rd_data, w_w;
    logic [VTX_BITS-1:0]    w_vidx, w_pv, w_ridx;
    logic [DIST_BITS-1:0]   w_rd;
    logic                   w_rinf, w_rset;
    logic [DIST_BITS:0]     w_sum;
    logic                   w_relax, w_cand, w_scan_end, w_in_hit;
    logic [CNT_BITS-1:0]    w_span;
    logic                   w_pwr;

    gsp_ram #(
        .WIDTH(WEIGHT_BITS),
        .DEPTH(EDGE_DEPTH)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign w_accept   = i_valid && (r_state == S_IDLE);
    assign o_stall    = (r_state != S_IDLE);
    assign w_can_emit = !r_ovalid || !i_stall;
    assign rd_addr    = {r_cur, r_v[VTX_BITS-1:0]};
    assign w_vidx     = r_v[VTX_BITS-1:0];
    assign w_pv       = w_vidx - VTX_BITS'(1);

    always_comb begin
        case (r_state)
            S_REL:   w_ridx = w_pv;
            S_DIST:  w_ridx = r_b;
            default: w_ridx = w_vidx;
        endcase
    end

    assign w_rd    = r_dist[w_ridx];
    assign w_rinf  = r_inf[w_ridx];
    assign w_rset  = r_settled[w_ridx];
    assign w_w     = r_rdv ? rd_data : '0;
    assign w_sum   = {1'b0, r_best} + (DIST_BITS+1)'(w_w);
    assign w_relax = (r_v != '0) && (w_w != '0) && (w_rinf || (w_sum < {1'b0, w_rd}));
    assign w_cand  = !w_rset && !w_rinf && (!r_found || (w_rd < r_best));

    always_comb begin
        if (32'(r_vcount) > VERTICES) begin
            w_span = CNT_BITS'(VERTICES);
        end else begin
            w_span = CNT_BITS'(r_vcount);
        end
    end

    assign w_scan_end = (r_v >= w_span);
    assign w_in_hit   = (w_vidx != r_a) && !w_rinf && (w_rd <= r_limit);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req_type)
                        REQ_EDGE:             n_state = S_EDGE2;
                        REQ_DIST, REQ_REACH:  n_state = S_SEL;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_EDGE2: n_state = S_IDLE;
            S_SEL: begin
                if (r_v == CNT_BITS'(VERTICES-1)) begin
                    if (r_found || w_cand) begin
                        n_state = S_REL;
                    end else if (r_type == REQ_DIST) begin
                        n_state = S_DIST;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_REL: begin
                if (r_v == CNT_BITS'(VERTICES)) begin
                    n_state = S_SEL;
                end
            end
            S_DIST: begin
                if (w_can_emit) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (w_can_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_type    = r_type;
        n_a       = r_a;
        n_b       = r_b;
        n_wt      = r_wt;
        n_cur     = r_cur;
        n_v       = r_v;
        n_best    = r_best;
        n_found   = r_found;
        n_settled = r_settled;
        n_inf     = r_inf;
        n_dist    = r_dist;
        n_pend    = r_pend;
        n_pvtx    = r_pvtx;
        n_pw      = r_pw;
        wr_en     = 1'b0;
        wr_addr   = {i_vertex_a, i_vertex_b};
        wr_data   = i_edge_weight;
        w_emit    = 1'b0;
        w_ehit    = 1'b0;
        w_evtx    = '0;
        w_epw     = '0;
        w_eunr    = 1'b0;
        w_elast   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_type = t_req'(i_req_type);
                    n_a    = i_vertex_a;
                    n_b    = i_vertex_b;
                    n_wt   = i_edge_weight;
                    if (i_req_type == REQ_EDGE) begin
                        wr_en = 1'b1;
                    end
                    n_inf             = '1;
                    n_inf[i_vertex_a] = 1'b0;
                    n_dist[i_vertex_a] = '0;
                    n_settled         = '0;
                    n_found           = 1'b0;
                    n_v               = '0;
                    n_pend            = 1'b0;
                end
            end
            S_EDGE2: begin
                wr_en   = 1'b1;
                wr_addr = {r_b, r_a};
                wr_data = r_wt;
            end
            S_SEL: begin
                if (w_cand) begin
                    n_found = 1'b1;
                    n_best  = w_rd;
                    n_cur   = w_vidx;
                end
                if (r_v == CNT_BITS'(VERTICES-1)) begin
                    n_v = '0;
                    if (w_cand) begin
                        n_settled[w_vidx] = 1'b1;
                    end else if (r_found) begin
                        n_settled[r_cur] = 1'b1;
                    end
                end else begin
                    n_v = r_v + CNT_BITS'(1);
                end
            end
            S_REL: begin
                if (w_relax) begin
                    n_dist[w_pv] = w_sum[DIST_BITS-1:0];
                    n_inf[w_pv]  = 1'b0;
                end
                if (r_v == CNT_BITS'(VERTICES)) begin
                    n_v     = '0;
                    n_found = 1'b0;
                end else begin
                    n_v = r_v + CNT_BITS'(1);
                end
            end
            S_DIST: begin
                w_emit  = w_can_emit;
                w_ehit  = !w_rinf;
                w_evtx  = r_b;
                w_epw   = w_rinf ? UNREACH_CODE : f_report(w_rd);
                w_eunr  = w_rinf;
                w_elast = 1'b1;
            end
            S_SCAN: begin
                if (!w_scan_end && !(w_in_hit && r_pend && !w_can_emit)) begin
                    n_v = r_v + CNT_BITS'(1);
                    if (w_in_hit) begin
                        w_emit = r_pend;
                        w_ehit = 1'b1;
                        w_evtx = r_pvtx;
                        w_epw  = r_pw;
                        n_pend = 1'b1;
                        n_pvtx = w_vidx;
                        n_pw   = f_report(w_rd);
                    end
                end
            end
            S_FLUSH: begin
                w_emit  = w_can_emit;
                w_ehit  = r_pend;
                w_evtx  = r_pend ? r_pvtx : '0;
                w_epw   = r_pend ? r_pw : '0;
                w_elast = 1'b1;
            end
            default: ;
        endcase

        n_ovalid = r_ovalid;
        n_ohit   = r_ohit;
        n_ovtx   = r_ovtx;
        n_opw    = r_opw;
        n_ounr   = r_ounr;
        n_olast  = r_olast;
        if (w_emit) begin
            n_ovalid = 1'b1;
            n_ohit   = w_ehit;
            n_ovtx   = w_evtx;
            n_opw    = w_epw;
            n_ounr   = w_eunr;
            n_olast  = w_elast;
        end else if (!i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    assign w_pwr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_vcount <= VCOUNT_RST;
            r_limit  <= LIMIT_RST;
            r_ev     <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (w_pwr) begin
                if (paddr[2]) begin
                    r_limit <= pwdata[DIST_BITS-1:0];
                end else begin
                    r_vcount <= pwdata[VCNT_BITS-1:0];
                end
            end
            if (wr_en) begin
                r_ev[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_type    <= n_type;
        r_a       <= n_a;
        r_b       <= n_b;
        r_wt      <= n_wt;
        r_cur     <= n_cur;
        r_v       <= n_v;
        r_best    <= n_best;
        r_found   <= n_found;
        r_settled <= n_settled;
        r_inf     <= n_inf;
        r_dist    <= n_dist;
        r_pend    <= n_pend;
        r_pvtx    <= n_pvtx;
        r_pw      <= n_pw;
        r_rdv     <= r_ev[rd_addr];
        r_ohit    <= n_ohit;
        r_ovtx    <= n_ovtx;
        r_opw     <= n_opw;
        r_ounr    <= n_ounr;
        r_olast   <= n_olast;
    end

    assign prdata        = paddr[2] ? {20'b0, r_limit} : {27'b0, r_vcount};
    assign pready        = 1'b1;
    assign o_valid       = r_ovalid;
    assign o_hit         = r_ohit;
    assign o_vertex_out  = r_ovtx;
    assign o_path_weight = r_opw;
    assign o_unreachable = r_ounr;
    assign o_last        = r_olast;

    `GSP_NEVER(a_no_overwrite, w_emit && r_ovalid && i_stall)
    `GSP_ASSERT(a_rel_settled, (r_state == S_REL) |-> r_settled[r_cur])
    `GSP_ASSERT(a_src_zero, (r_state == S_SEL) |-> (!r_inf[r_a] && (r_dist[r_a] == '0)))
    `GSP_ASSERT(a_last_idle, (w_emit && w_elast) |=> (r_state == S_IDLE))

endmodule

### rtl/gsp_ram.sv
module gsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### test/graph_shortest_path_reach_top_tb.sv
`default_nettype none
module graph_shortest_path_reach_top_tb import gsp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int REG_VCOUNT = 0;
    localparam int REG_LIMIT  = 1;
    localparam int QUERY_SETTLE = 700;
    localparam int LONG_HOLD = 2000;
    localparam int IDLE_LIMIT = 20000;
    localparam int unsigned NO_PATH = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        hit;
        logic [3:0]  vtx;
        logic [11:0] weight;
        logic        unr;
        logic        last;
    } path_result_t;

    typedef struct {
        logic [1:0]   kind;
        logic [3:0]   a;
        logic [3:0]   b;
        logic [7:0]   w;
        bit           typed;
        path_result_t answer;
    } request_row_t;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic [1:0] i_req_type;
    logic [3:0] i_vertex_a, i_vertex_b, o_vertex_out;
    logic [7:0] i_edge_weight;
    logic o_hit, o_unreachable, o_last;
    logic [11:0] o_path_weight;
    logic psel, penable, pwrite, pready;
    logic [PADDR_BITS-1:0] paddr;
    logic [31:0] pwdata, prdata;

    graph_shortest_path_reach_top dut (.*);

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    logic [7:0]   graph_w [VERTICES][VERTICES];
    int unsigned  dist_tab [VERTICES];
    int unsigned  model_vcount, model_limit;
    path_result_t pending_results [$];
    int failures, requests_taken, results_taken, reg_writes, idle_cycles;
    bit hold_long, activity;

    task automatic add_expected(input path_result_t r);
        pending_results.insert(pending_results.size(), r);
    endtask

    task automatic shortest_from(input int src);
        bit settled [VERTICES];
        int cur;
        int unsigned best;
        for (int v = 0; v < VERTICES; v++) begin
            dist_tab[v] = NO_PATH;
            settled[v] = 1'b0;
        end
        dist_tab[src] = 0;
        for (int r = 0; r < VERTICES; r++) begin
            best = NO_PATH;
            cur = -1;
            for (int v = 0; v < VERTICES; v++)
                if (!settled[v] && dist_tab[v] < best) begin
                    best = dist_tab[v];
                    cur = v;
                end
            if (cur < 0) break;
            settled[cur] = 1'b1;
            for (int v = 0; v < VERTICES; v++)
                if (graph_w[cur][v] != 0 && best + graph_w[cur][v] < dist_tab[v])
                    dist_tab[v] = best + graph_w[cur][v];
        end
    endtask

    function automatic logic [11:0] capped(input int unsigned d);
        return (d > TOP_REACH) ? TOP_REACH : d[11:0];
    endfunction

    task automatic predict_paths(input request_row_t rq);
        int listed;
        int unsigned span;
        case (rq.kind)
            REQ_EDGE: begin
                graph_w[rq.a][rq.b] = rq.w;
                graph_w[rq.b][rq.a] = rq.w;
            end
            REQ_DIST: begin
                shortest_from(rq.a);
                if (dist_tab[rq.b] == NO_PATH)
                    add_expected({1'b0, rq.b, UNREACH_CODE, 1'b1, 1'b1});
                else
                    add_expected({1'b1, rq.b, capped(dist_tab[rq.b]), 2'b01});
            end
            REQ_REACH: begin
                listed = 0;
                span = (model_vcount < VERTICES) ? model_vcount : VERTICES;
                shortest_from(rq.a);
                for (int i = 0; i < span && listed < 16; i++) begin
                    if (i == rq.a || dist_tab[i] == NO_PATH || dist_tab[i] > model_limit)
                        continue;
                    add_expected({1'b1, 4'(i), capped(dist_tab[i]), 2'b00});
                    listed++;
                end
                if (listed == 0)
                    add_expected({1'b0, 4'd0, 12'd0, 1'b0, 1'b1});
                else
                    pending_results[pending_results.size()-1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send_request(input request_row_t rq);
        int gap;
        bit taken;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= rq.kind;
        i_vertex_a <= rq.a;
        i_vertex_b <= rq.b;
        i_edge_weight <= rq.w;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        requests_taken++;
        if (rq.typed) begin
            predict_paths(rq);
            void'(pending_results.pop_back());
            add_expected(rq.answer);
        end else begin
            predict_paths(rq);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (QUERY_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_BITS'(4 * idx);
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (prdata != value) begin
            $error("readback reg %0d: expected %0h actual %0h", idx, value, prdata);
            failures++;
        end
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        activity = 1'b1;
        reg_writes++;
        if (idx == REG_VCOUNT) model_vcount = value;
        else model_limit = value;
    endtask

    task automatic set_phase(input int vc, input int lim);
        wait_drained();
        write_reg(REG_VCOUNT, 32'(vc));
        write_reg(REG_LIMIT, 32'(lim));
    endtask

    function automatic request_row_t random_request();
        request_row_t rq;
        int pick;
        pick = $urandom_range(0, 99);
        rq.kind = (pick < 45) ? REQ_EDGE : (pick < 70) ? REQ_DIST :
                  (pick < 95) ? REQ_REACH : REQ_UNUSED;
        rq.a = $urandom_range(0, 15);
        rq.b = $urandom_range(0, 15);
        pick = $urandom_range(0, 9);
        rq.w = (pick == 0) ? 8'd0 : (pick < 8) ? 8'($urandom_range(1, 12)) :
               8'($urandom_range(0, 255));
        rq.typed = 1'b0;
        rq.answer = '0;
        return rq;
    endfunction

    // receiver: random stall per result, one long hold on request
    initial begin
        int n;
        bit got;
        i_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = hold_long ? LONG_HOLD : draw_gap();
            hold_long = 1'b0;
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                got = o_valid;
                @(posedge i_clk);
            end while (!got);
        end
    end

    always @(negedge i_clk) begin
        path_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_taken++;
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: vertex %0d", o_vertex_out);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, o_hit); failures++;
                end
                if (o_vertex_out !== want.vtx) begin
                    $error("vertex_out: expected %0d actual %0d", want.vtx, o_vertex_out);
                    failures++;
                end
                if (o_path_weight !== want.weight) begin
                    $error("path_weight: expected %0d actual %0d", want.weight,
                           o_path_weight);
                    failures++;
                end
                if (o_unreachable !== want.unr) begin
                    $error("unreachable: expected %0d actual %0d", want.unr, o_unreachable);
                    failures++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d actual %0d", want.last, o_last); failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || activity) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        activity = 1'b0;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    request_row_t directed [] = '{
        '{REQ_DIST,   4'd0,  4'd15, 8'd0,   1, '{1'b0, 4'd15, 12'hFFF, 1'b1, 1'b1}},
        '{REQ_DIST,   4'd3,  4'd3,  8'd0,   1, '{1'b1, 4'd3,  12'd0,   1'b0, 1'b1}},
        '{REQ_REACH,  4'd0,  4'd0,  8'd0,   1, '{1'b0, 4'd0,  12'd0,   1'b0, 1'b1}},
        '{REQ_UNUSED, 4'd15, 4'd15, 8'hFF,  0, '0},
        '{REQ_EDGE,   4'd0,  4'd1,  8'd255, 0, '0},
        '{REQ_EDGE,   4'd15, 4'd15, 8'd1,   0, '0},
        '{REQ_EDGE,   4'd1,  4'd2,  8'd1,   0, '0},
        '{REQ_EDGE,   4'd2,  4'd3,  8'd2,   0, '0},
        '{REQ_DIST,   4'd0,  4'd3,  8'd0,   0, '0},
        '{REQ_REACH,  4'd1,  4'd0,  8'd0,   0, '0},
        '{REQ_REACH,  4'd0,  4'd0,  8'd0,   0, '0},
        '{REQ_EDGE,   4'd0,  4'd1,  8'd0,   0, '0},
        '{REQ_DIST,   4'd0,  4'd1,  8'd0,   1, '{1'b0, 4'd1,  12'hFFF, 1'b1, 1'b1}},
        '{REQ_EDGE,   4'd14, 4'd15, 8'hAA,  0, '0},
        '{REQ_EDGE,   4'd13, 4'd14, 8'h55,  0, '0},
        '{REQ_DIST,   4'd13, 4'd15, 8'd0,   0, '0},
        '{REQ_DIST,   4'd15, 4'd15, 8'd0,   1, '{1'b1, 4'd15, 12'd0,   1'b0, 1'b1}},
        '{REQ_REACH,  4'd15, 4'd0,  8'd0,   0, '0},
        '{REQ_EDGE,   4'd3,  4'd12, 8'd1,   0, '0},
        '{REQ_REACH,  4'd2,  4'd0,  8'd0,   0, '0}
    };

    initial begin
        int phase_vc [5];
        int phase_lim [5];
        phase_vc = '{31, 1, 0, 7, 16};
        phase_lim = '{4095, 0, 50, 200, 20};
        failures = 0; requests_taken = 0; results_taken = 0; reg_writes = 0;
        idle_cycles = 0; hold_long = 1'b0; activity = 1'b0;
        model_vcount = VCOUNT_RST; model_limit = LIMIT_RST;
        foreach (graph_w[i, j]) graph_w[i][j] = '0;
        i_rst_n <= 1'b0; i_valid <= 1'b0;
        i_req_type <= REQ_EDGE; i_vertex_a <= '0; i_vertex_b <= '0; i_edge_weight <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) send_request(directed[k]);

        for (int p = 0; p < 5; p++) begin
            set_phase(phase_vc[p], phase_lim[p]);
            if (p == 0) hold_long = 1'b1;
            for (int k = 0; k < 24; k++) send_request(random_request());
            if (p == 2) wait_drained();
            for (int k = 0; k < 4; k++) send_request(random_request());
        end

        wait_drained();
        $display("requests %0d, results %0d, register writes %0d", requests_taken,
                 results_taken, reg_writes);
        $display("covered edge set/remove, distance and reach queries over 6 settings");
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/gsp_pkg.sv
rtl/gsp_ram.sv
rtl/graph_shortest_path_reach_top.sv
test/graph_shortest_path_reach_top_tb.sv
